// ===== rtl/core/r2ca_pkg.sv =====
// ----------------------------------------------------------------------------
// r2ca_pkg
// Shared widths, register indexes and controller/datapath interface types for
// the radius-two ring cellular automaton.
// ----------------------------------------------------------------------------
package r2ca_pkg;

  localparam int unsigned RuleW   = 32;
  localparam int unsigned StepW   = 7;
  localparam int unsigned GenW    = 6;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [StepW-1:0] MaxSteps = 7'd64;

  localparam logic [RuleW-1:0] RuleReset = 32'hFEE8E880;
  localparam logic [StepW-1:0] StepReset = 7'd6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegRuleTable = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStepCount = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // load a new initial row, generation index back to zero
    logic step;  // emit the current row and advance one generation
  } r2ca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steps_zero;  // configured step count is zero
    logic final_gen;   // current generation is the last one to emit
    logic out_free;    // output register can take a word this cycle
  } r2ca_status_t;

endpackage

// ===== rtl/core/r2ca_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2ca_ctrl
// Controller state machine: accepts an initial row and sequences the
// generations through the datapath.
// ----------------------------------------------------------------------------
module r2ca_ctrl import r2ca_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  r2ca_status_t status_i,
  output r2ca_cmd_t    cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.steps_zero) begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.final_gen) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/r2ca_datapath.sv =====
// ----------------------------------------------------------------------------
// r2ca_datapath
// Configuration registers, the cell ring with its next-generation logic, the
// generation counter and the output register.
// ----------------------------------------------------------------------------
module r2ca_datapath import r2ca_pkg::*; #(
  parameter int unsigned CELLS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic [WordW-1:0]   initial_state_i,
  input  r2ca_cmd_t          cmd_i,
  output r2ca_status_t       status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [GenW-1:0]    generation_o,
  output logic [WordW-1:0]   packed_row_o,
  output logic               last_o
);

  logic [RuleW-1:0] rule_q;
  logic [StepW-1:0] steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q  <= RuleReset;
      steps_q <= StepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegRuleTable: rule_q  <= cfg_data_i[RuleW-1:0];
        RegStepCount: steps_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Step counts above the maximum saturate.
  logic [StepW-1:0] steps_sat;
  assign steps_sat = (steps_q > MaxSteps) ? MaxSteps : steps_q;

  logic [CELLS-1:0] row_q, row_d;
  logic [CELLS-1:0] row_next;
  logic [CELLS-1:0] row_init;
  logic [CELLS-1:0] row_rev;
  logic [WordW-1:0] packed_now;
  logic [GenW-1:0]  gen_q, gen_d;

  // Load the initial word: cells beyond the word start at zero.
  if (CELLS >= WordW) begin : g_init_wide
    assign row_init = {{(CELLS-WordW){1'b0}}, initial_state_i};
  end else begin : g_init_narrow
    assign row_init = initial_state_i[CELLS-1:0];
  end

  // One generation of the ring, each cell looking two places either way.
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    localparam int unsigned Lm2 = (j + CELLS - 2) % CELLS;
    localparam int unsigned Lm1 = (j + CELLS - 1) % CELLS;
    localparam int unsigned Rp1 = (j + 1) % CELLS;
    localparam int unsigned Rp2 = (j + 2) % CELLS;
    logic [4:0] code;
    assign code        = {row_q[Lm2], row_q[Lm1], row_q[j], row_q[Rp1], row_q[Rp2]};
    assign row_next[j] = rule_q[code];
    assign row_rev[CELLS-1-j] = row_q[j];
  end

  // Packed row keeps the low word of the reversed ring.
  if (CELLS >= WordW) begin : g_pack_wide
    assign packed_now = row_rev[WordW-1:0];
  end else begin : g_pack_narrow
    assign packed_now = {{(WordW-CELLS){1'b0}}, row_rev};
  end

  logic final_gen;
  assign final_gen = ({1'b0, gen_q} + 7'd1) == steps_sat;

  always_comb begin
    row_d = row_q;
    gen_d = gen_q;
    if (cmd_i.load) begin
      row_d = row_init;
      gen_d = '0;
    end else if (cmd_i.step) begin
      row_d = row_next;
      gen_d = gen_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      gen_q <= '0;
    end else begin
      row_q <= row_d;
      gen_q <= gen_d;
    end
  end

  // Output register decouples the sink from the ring.
  logic            out_valid_q, out_valid_d;
  logic [GenW-1:0] out_gen_q;
  logic [WordW-1:0] out_row_q;
  logic            out_last_q;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_gen_q  <= gen_q;
      out_row_q  <= packed_now;
      out_last_q <= final_gen;
    end
  end

  assign status_o.steps_zero = (steps_sat == '0);
  assign status_o.final_gen  = final_gen;
  assign status_o.out_free   = out_free;

  assign out_valid_o  = out_valid_q;
  assign generation_o = out_gen_q;
  assign packed_row_o = out_row_q;
  assign last_o       = out_last_q;

endmodule

// ===== rtl/core/radius2_ring_cellular_automaton_top.sv =====
// ----------------------------------------------------------------------------
// radius2_ring_cellular_automaton_top
// One-dimensional radius-two cellular automaton on a wrapping ring of cells.
// ----------------------------------------------------------------------------
// Each accepted input word is loaded into a ring of CELLS binary cells, bit m
// into cell m, and the block then emits one output word per generation for
// generations 0 up to step_count-1. A generation is computed by the
// combinational next-state logic of the ring, the step count is six at the
// default setting, and back-pressure on the output simply stalls the ring.
// Each output word carries the generation index, the row packed with cell 0
// as the most significant bit (the low 32 bits of that packing when the ring
// is wider than 32 cells), and a last flag on the final row. A step count of
// zero emits nothing, and counts above 64 are treated as 64. A new input is
// taken as soon as the final row of the previous one sits in the output
// register. The user must write the rule table and step count through the
// configuration port only while the block is idle; the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
module radius2_ring_cellular_automaton_top import r2ca_pkg::*; #(
  parameter int unsigned CELLS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WordW-1:0]   initial_state_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [GenW-1:0]    generation_o,
  output logic [WordW-1:0]   packed_row_o,
  output logic               last_o
);

  r2ca_cmd_t    cmd;
  r2ca_status_t status;

  // The controller decides when a word is loaded and when the ring advances.
  r2ca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the ring, the generation counter and the output register.
  r2ca_datapath #(
    .CELLS (CELLS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .initial_state_i (initial_state_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .generation_o    (generation_o),
    .packed_row_o    (packed_row_o),
    .last_o          (last_o)
  );

endmodule

// ===== test/radius2_ring_cellular_automaton_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radius-two ring cellular automaton. A shadow copy
// of the rule table and step count drives an in-bench predictor that evolves
// each initial row and queues the generation words it must produce; every word
// the block emits is checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module testbench;
  import r2ca_pkg::*;

  localparam int unsigned Cells        = 32;
  // Longest run of one input (saturated step count) plus load and margin.
  localparam int unsigned SettleCycles = 80;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned IdlePercent  = 19;
  localparam int unsigned MaxPrinted   = 30;

  // One generation word as the output channel carries it.
  typedef struct packed {
    logic [GenW-1:0]  gen;
    logic [WordW-1:0] cells;
    logic             last;
  } gen_word_t;

  // All block inputs start at known values; reset is held from time zero.
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i     = RegRuleTable;
  logic [WordW-1:0]   cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [WordW-1:0]   initial_state_i = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [GenW-1:0]    generation_o;
  logic [WordW-1:0]   packed_row_o;
  logic               last_o;

  // Shadow of the configuration registers, updated with every write.
  logic [RuleW-1:0]   rule_bits    = RuleReset;
  logic [StepW-1:0]   step_setting = StepReset;

  // Generation words the block still owes, oldest first.
  gen_word_t          pending_rows[$];

  // When set, neither side inserts idle cycles.
  bit                 calm = 1'b0;

  int                 mismatches     = 0;
  int                 rows_sent      = 0;
  int                 words_checked  = 0;
  int                 settings_used  = 0;
  int                 stall_cycles   = 0;

  always #10 clk_i = ~clk_i;

  radius2_ring_cellular_automaton_top #(
    .CELLS(Cells)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .initial_state_i(initial_state_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .generation_o   (generation_o),
    .packed_row_o   (packed_row_o),
    .last_o         (last_o)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One generation of the ring: each cell looks two cells to either side,
  // wrapping at both ends, and the five bits select one bit of the rule.
  function automatic logic [WordW-1:0] next_row(input logic [WordW-1:0] row,
                                                input logic [RuleW-1:0] rule_now);
    logic [WordW-1:0] nxt;
    logic [4:0]       code;
    int               j;
    nxt = '0;
    for (j = 0; j < Cells; j++) begin
      code = {row[(j + Cells - 2) % Cells], row[(j + Cells - 1) % Cells], row[j],
              row[(j + 1) % Cells], row[(j + 2) % Cells]};
      nxt[j] = rule_now[code];
    end
    return nxt;
  endfunction

  // The output puts cell 0 in the most significant bit.
  function automatic logic [WordW-1:0] reverse_cells(input logic [WordW-1:0] row);
    logic [WordW-1:0] packed_bits;
    int               c;
    for (c = 0; c < Cells; c++) begin
      packed_bits[Cells - 1 - c] = row[c];
    end
    return packed_bits;
  endfunction

  // Queue every generation word one initial row will produce under the
  // current setting. A step count of zero queues nothing; counts above the
  // maximum are clipped to it.
  function automatic void predict_rows(input logic [WordW-1:0] start);
    logic [WordW-1:0] row;
    int unsigned      count;
    int unsigned      g;
    gen_word_t        w;
    count = (step_setting > MaxSteps) ? MaxSteps : step_setting;
    row   = start;
    for (g = 0; g < count; g++) begin
      w.gen   = GenW'(g);
      w.cells = reverse_cells(row);
      w.last  = (g + 1 == count);
      pending_rows = {pending_rows, w};
      row = next_row(row, rule_bits);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Present one initial row and return in the time step where it is taken.
  // Valid is left high so that a following call can keep the channel busy
  // without a gap; whoever comes next either drives a new word or lowers it.
  task automatic send_row(input logic [WordW-1:0] start);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePercent);
    end
    in_valid_i      <= 1'b1;
    initial_state_i <= start;
    predict_rows(start);
    rows_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending, wait for every owed word, then give the block time to finish
  // a run that owes nothing (step count zero) before anything else happens.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [WordW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (index)
      RegRuleTable: begin
        rule_bits = data[RuleW-1:0];
      end
      RegStepCount: begin
        step_setting = data[StepW-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  // Both registers are rewritten only once the block has gone idle.
  task automatic configure(input logic [RuleW-1:0] rule_now, input logic [WordW-1:0] step_data);
    settle_block();
    write_reg(RegRuleTable, rule_now);
    write_reg(RegStepCount, step_data);
    settings_used++;
  endtask

  // Step counts lean toward short runs, with the full length, the clipped
  // range and zero mixed in. Bits above the register width are random.
  function automatic logic [WordW-1:0] random_step_data();
    logic [WordW-1:0] data;
    int unsigned      pick;
    data = $urandom;
    pick = $urandom_range(99);
    if (pick < 70)      data[StepW-1:0] = StepW'($urandom_range(8, 1));
    else if (pick < 82) data[StepW-1:0] = StepW'($urandom_range(63, 9));
    else if (pick < 88) data[StepW-1:0] = MaxSteps;
    else if (pick < 94) data[StepW-1:0] = StepW'($urandom_range(127, 65));
    else                data[StepW-1:0] = '0;
    return data;
  endfunction

  function automatic logic [RuleW-1:0] random_rule();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return '0;
    if (pick < 8) return '1;
    return $urandom;
  endfunction

  // Mostly dense random rows; some sparse rows that exercise the wrap.
  function automatic logic [WordW-1:0] random_state();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return WordW'(1) << $urandom_range(Cells - 1);
    if (pick < 12) return ~(WordW'(1) << $urandom_range(Cells - 1));
    if (pick < 16) return $urandom & $urandom & $urandom;
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and the word checker
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // Outputs are sampled at the edge, before anything driven at that edge
  // takes effect, so the handshake seen here is the one the block sees.
  always @(posedge clk_i) begin
    gen_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected word: generation %0d row %h last %b",
                                  generation_o, packed_row_o, last_o));
      end else begin
        want = pending_rows.pop_front();
        if (generation_o !== want.gen) begin
          report_mismatch($sformatf("generation: got %0d, expected %0d",
                                    generation_o, want.gen));
        end
        if (packed_row_o !== want.cells) begin
          report_mismatch($sformatf("packed_row at generation %0d: got %h, expected %h",
                                    want.gen, packed_row_o, want.cells));
        end
        if (last_o !== want.last) begin
          report_mismatch($sformatf("last at generation %0d: got %b, expected %b",
                                    want.gen, last_o, want.last));
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: %0d cycles without a transfer, %0d words still owed",
               stall_cycles, pending_rows.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers left at their reset values: all-zero and all-one rows, a single
  // cell at either end of the ring, and the two alternating patterns.
  task automatic test_default_setting();
    send_row(32'h0000_0000);
    send_row(32'hFFFF_FFFF);
    send_row(32'h0000_0001);
    send_row(32'h8000_0000);
    send_row(32'hAAAA_AAAA);
    send_row(32'h5555_5555);
  endtask

  // Empty and full rule tables, and a rule that only lights an empty
  // neighbourhood, so the ring blinks between all zeros and all ones.
  task automatic test_rule_extremes();
    configure(32'h0000_0000, 32'd4);
    send_row(32'hFFFF_FFFF);
    send_row(random_state());
    configure(32'hFFFF_FFFF, 32'd4);
    send_row(32'h0000_0000);
    send_row(random_state());
    configure(32'h0000_0001, 32'd5);
    send_row(32'h0000_0000);
  endtask

  // Single-generation runs, full-length runs, zero steps (the row is taken
  // but nothing comes out), and counts above the maximum, which are clipped.
  // The last write also sets every data bit above the register.
  task automatic test_step_extremes();
    configure($urandom, 32'd1);
    send_row(random_state());
    send_row(random_state());
    configure($urandom, MaxSteps);
    send_row(random_state());
    send_row(32'h0000_8000);
    configure($urandom, 32'd0);
    send_row(random_state());
    send_row(32'hFFFF_FFFF);
    configure($urandom, 32'd65);
    send_row(random_state());
    configure($urandom, 32'hFFFF_FFFF);
    send_row(random_state());
  endtask

  // Random rows under a fresh random setting every forty rows.
  task automatic test_random_rows(input int count, input bit quiet);
    int i;
    calm = quiet;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        configure(random_rule(), random_step_data());
      end
      send_row(random_state());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_setting();
    test_rule_extremes();
    test_step_extremes();
    // A long stretch with both channels running flat out, then random idling.
    test_random_rows(160, 1'b1);
    test_random_rows(320, 1'b0);

    settle_block();
    $display("Sent %0d initial rows under %0d register settings, checked %0d words.",
             rows_sent, settings_used, words_checked);
    $display("Covered both rule table extremes, step counts of 0, 1 and 64, and clipped counts.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
